// ----- rtl/core/rsl_pkg.sv -----
// ----------------------------------------------------------------------------
// rsl_pkg
// Shared widths, constants and the quarter-wave sine table for the raster
// line offset generator.
// ----------------------------------------------------------------------------
package rsl_pkg;

  localparam int RowW     = 10;
  localparam int LeftW    = 12;
  localparam int DestW    = 13;
  localparam int AmpW     = 10;
  localparam int AngW     = 9;
  localparam int IdxW     = 7;
  localparam int SinW     = 17;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 10;

  localparam int MaxRows  = 1024;
  localparam int DegFull  = 360;
  localparam int Quarter  = 90;
  localparam int RomSize  = 91;

  // angle sum: row*step + base stays below 2^17
  localparam int SumW       = 17;
  // floor(x/360) = (x * RecipK) >> RecipShift, exact for x < 2^17
  localparam int RecipShift = 25;
  localparam int RecipK     = (2**RecipShift + DegFull - 1) / DegFull;
  localparam int RecipW     = 2 * SumW;

  localparam int ScaleW     = SinW + AmpW;
  localparam int RoundBias  = 32767;
  localparam int ScaleShift = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAmplitude = 1'b0,
    CfgAngleStep = 1'b1
  } cfg_idx_e;

  // words that ride along the pipeline untouched
  typedef struct packed {
    logic signed [LeftW-1:0] left;
    logic [RowW-1:0]         row;
  } tag_t;

  localparam logic [SinW-1:0] SineRom [RomSize] = '{
        17'd0,  17'd1143,  17'd2287,  17'd3429,  17'd4571,  17'd5711,  17'd6850,
     17'd7986,  17'd9120, 17'd10252, 17'd11380, 17'd12504, 17'd13625, 17'd14742,
    17'd15854, 17'd16961, 17'd18064, 17'd19160, 17'd20251, 17'd21336, 17'd22414,
    17'd23486, 17'd24550, 17'd25606, 17'd26655, 17'd27696, 17'd28729, 17'd29752,
    17'd30767, 17'd31772, 17'd32768, 17'd33753, 17'd34728, 17'd35693, 17'd36647,
    17'd37589, 17'd38521, 17'd39440, 17'd40347, 17'd41243, 17'd42125, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46340, 17'd47142, 17'd47929, 17'd48702,
    17'd49460, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53019, 17'd53683,
    17'd54331, 17'd54963, 17'd55577, 17'd56175, 17'd56755, 17'd57319, 17'd57864,
    17'd58393, 17'd58903, 17'd59395, 17'd59870, 17'd60326, 17'd60763, 17'd61183,
    17'd61583, 17'd61965, 17'd62328, 17'd62672, 17'd62997, 17'd63302, 17'd63589,
    17'd63856, 17'd64103, 17'd64331, 17'd64540, 17'd64729, 17'd64898, 17'd65047,
    17'd65176, 17'd65286, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  function automatic logic [SinW-1:0] sine_lookup(input logic [IdxW-1:0] idx);
    logic [SinW-1:0] val;
    val = '0;
    if (idx < IdxW'(RomSize)) begin
      val = SineRom[idx];
    end
    return val;
  endfunction

endpackage

// ----- rtl/core/rsl_if.sv -----
// ----------------------------------------------------------------------------
// rsl_if
// Stream interfaces for line requests and line results.
// ----------------------------------------------------------------------------
interface rsl_in_if
  import rsl_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [RowW-1:0]         row;
  logic signed [LeftW-1:0] left_x;

  modport source (output valid, command, row, left_x, input ready);
  modport sink   (input valid, command, row, left_x, output ready);
endinterface

interface rsl_out_if
  import rsl_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [DestW-1:0] dest_x;
  logic [RowW-1:0]         row_out;

  modport source (output valid, dest_x, row_out, input ready);
  modport sink   (input valid, dest_x, row_out, output ready);
endinterface

// ----- rtl/core/rsl_wave.sv -----
// ----------------------------------------------------------------------------
// rsl_wave
// Two-stage sine unit: quadrant fold and table read, then amplitude scaling
// with rounding. Returns magnitude and sign of the displacement.
// ----------------------------------------------------------------------------
module rsl_wave
  import rsl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [AngW-1:0] ang_i,
  input  tag_t            tag_i,
  input  logic [AmpW-1:0] amp_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [AmpW-1:0] mag_o,
  output logic            neg_o,
  output tag_t            tag_o
);

  logic            valid_e_q, valid_f_q;
  logic            en_e, en_f;
  logic [IdxW-1:0] idx;
  logic            neg;
  logic [SinW-1:0] v_e_d, v_e_q;
  logic            neg_e_q, neg_f_q;
  tag_t            tag_e_q, tag_f_q;
  logic [ScaleW-1:0] scaled;
  logic [AmpW-1:0] mag_f_d, mag_f_q;

  assign en_f       = !valid_f_q || out_ready_i;
  assign en_e       = !valid_e_q || en_f;
  assign in_ready_o = en_e;

  // fold into the first quadrant
  always_comb begin
    if (ang_i <= AngW'(Quarter)) begin
      idx = IdxW'(ang_i);
      neg = 1'b0;
    end else if (ang_i <= AngW'(2 * Quarter)) begin
      idx = IdxW'(AngW'(2 * Quarter) - ang_i);
      neg = 1'b0;
    end else if (ang_i <= AngW'(3 * Quarter)) begin
      idx = IdxW'(ang_i - AngW'(2 * Quarter));
      neg = 1'b1;
    end else begin
      idx = IdxW'(AngW'(DegFull) - ang_i);
      neg = 1'b1;
    end
    v_e_d = sine_lookup(idx);
  end

  assign scaled  = (ScaleW'(v_e_q) * ScaleW'(amp_i) + ScaleW'(RoundBias)) >> ScaleShift;
  assign mag_f_d = scaled[AmpW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_e_q <= 1'b0;
      valid_f_q <= 1'b0;
    end else begin
      if (en_e) valid_e_q <= in_valid_i;
      if (en_f) valid_f_q <= valid_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      v_e_q   <= v_e_d;
      neg_e_q <= neg;
      tag_e_q <= tag_i;
    end
    if (en_f) begin
      mag_f_q <= mag_f_d;
      neg_f_q <= neg_e_q;
      tag_f_q <= tag_e_q;
    end
  end

  assign out_valid_o = valid_f_q;
  assign mag_o       = mag_f_q;
  assign neg_o       = neg_f_q;
  assign tag_o       = tag_f_q;

`ifndef ASSERT_OFF
  a_rom_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_e_q |-> v_e_q <= SinW'(65536))
    else $error("sine table word out of range");

  a_f_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_f_q && !out_ready_i |=> valid_f_q && $stable(mag_f_q) && $stable(tag_f_q))
    else $error("scaled word lost while stalled");

  a_e_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_e_q && !en_f |=> valid_e_q && $stable(v_e_q) && $stable(tag_e_q))
    else $error("table word lost while stalled");
`endif

endmodule

// ----- rtl/core/raster_sine_line_offset.sv -----
// ----------------------------------------------------------------------------
// raster_sine_line_offset
// Raster-scroll line offset generator on a quarter-wave sine table.
// ----------------------------------------------------------------------------
// Accepts one word per cycle unless stalled. A frame-advance word adds
// angle_step to the base angle in the cycle it is taken and yields no result;
// line words taken after it see the new angle. A line word returns left_x plus
// the sine displacement through its registered steps (row mod 360, row*step
// multiply, reciprocal multiply, remainder, table read, amplitude multiply,
// output register), one result per cycle while the output is not stalled.
// Results stall stage by stage, so bubbles collapse while the output waits.
module raster_sine_line_offset
  import rsl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rsl_in_if.sink              req_i,
  rsl_out_if.source           res_o
);

  logic [AmpW-1:0] amp_q;
  logic [AngW-1:0] step_q, base_q, base_d;
  logic [AngW:0]   base_sum;

  logic            acc, line;
  logic            en_a, en_b, en_c, en_d, en_out, wave_ready;
  logic            valid_a_q, valid_b_q, valid_c_q, valid_d_q, out_valid_q;

  logic [AngW-1:0] rmod_a_d, rmod_a_q, smod_a_d, smod_a_q, base_a_q;
  tag_t            tag_a_q, tag_b_q, tag_c_q, tag_d_q;
  logic [SumW-1:0] sum_b_d, sum_b_q, sum_c_q;
  logic [RecipW-1:0] recip_c_d, recip_c_q;
  logic [AngW-1:0] quot;
  logic [SumW-1:0] rem;
  logic [AngW-1:0] ang_d_q;

  logic            wave_valid, wave_neg;
  logic [AmpW-1:0] wave_mag;
  tag_t            wave_tag;
  logic signed [DestW-1:0] disp, dest_d, dest_q;
  logic [RowW-1:0] row_q;

  assign acc  = req_i.valid && req_i.ready;
  assign line = req_i.command && ({1'b0, req_i.row} < (RowW + 1)'(MaxRows));

  assign en_out      = !out_valid_q || res_o.ready;
  assign en_d        = !valid_d_q || wave_ready;
  assign en_c        = !valid_c_q || en_d;
  assign en_b        = !valid_b_q || en_c;
  assign en_a        = !valid_a_q || en_b;
  assign req_i.ready = en_a;

  // config and frame angle; sum of two angles reaches 718, one bit wider
  always_comb begin
    base_sum = {1'b0, base_q} + {1'b0, smod_a_d};
    base_d   = base_q;
    if (acc && !req_i.command) begin
      if (base_sum >= (AngW + 1)'(DegFull)) begin
        base_d = AngW'(base_sum - (AngW + 1)'(DegFull));
      end else begin
        base_d = base_sum[AngW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q  <= AmpW'(1);
      step_q <= AngW'(1);
      base_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgAmplitude) amp_q  <= cfg_data_i[AmpW-1:0];
      if (cfg_we_i && cfg_idx_i == CfgAngleStep) step_q <= cfg_data_i[AngW-1:0];
      base_q <= base_d;
    end
  end

  // stage a: reduce row and step mod 360
  always_comb begin
    if (req_i.row >= RowW'(2 * DegFull)) begin
      rmod_a_d = AngW'(req_i.row - RowW'(2 * DegFull));
    end else if (req_i.row >= RowW'(DegFull)) begin
      rmod_a_d = AngW'(req_i.row - RowW'(DegFull));
    end else begin
      rmod_a_d = AngW'(req_i.row);
    end
    smod_a_d = (step_q >= AngW'(DegFull)) ? step_q - AngW'(DegFull) : step_q;
  end

  // stage b: row*step + base; stage c: reciprocal product; stage d: remainder
  assign sum_b_d   = SumW'(rmod_a_q) * SumW'(smod_a_q) + SumW'(base_a_q);
  assign recip_c_d = RecipW'(sum_b_q) * RecipW'(RecipK);
  assign quot      = recip_c_q[RecipShift +: AngW];
  assign rem       = sum_c_q - SumW'(quot) * SumW'(DegFull);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q   <= 1'b0;
      valid_b_q   <= 1'b0;
      valid_c_q   <= 1'b0;
      valid_d_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_a)   valid_a_q   <= req_i.valid && line;
      if (en_b)   valid_b_q   <= valid_a_q;
      if (en_c)   valid_c_q   <= valid_b_q;
      if (en_d)   valid_d_q   <= valid_c_q;
      if (en_out) out_valid_q <= wave_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      rmod_a_q <= rmod_a_d;
      smod_a_q <= smod_a_d;
      base_a_q <= base_q;
      tag_a_q  <= '{left: req_i.left_x, row: req_i.row};
    end
    if (en_b) begin
      sum_b_q <= sum_b_d;
      tag_b_q <= tag_a_q;
    end
    if (en_c) begin
      recip_c_q <= recip_c_d;
      sum_c_q   <= sum_b_q;
      tag_c_q   <= tag_b_q;
    end
    if (en_d) begin
      ang_d_q <= rem[AngW-1:0];
      tag_d_q <= tag_c_q;
    end
    if (en_out) begin
      dest_q <= dest_d;
      row_q  <= wave_tag.row;
    end
  end

  rsl_wave u_wave (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_d_q),
    .in_ready_o  (wave_ready),
    .ang_i       (ang_d_q),
    .tag_i       (tag_d_q),
    .amp_i       (amp_q),
    .out_valid_o (wave_valid),
    .out_ready_i (en_out),
    .mag_o       (wave_mag),
    .neg_o       (wave_neg),
    .tag_o       (wave_tag)
  );

  assign disp   = wave_neg ? -$signed(DestW'(wave_mag)) : $signed(DestW'(wave_mag));
  assign dest_d = DestW'($signed(wave_tag.left)) + disp;

  assign res_o.valid   = out_valid_q;
  assign res_o.dest_x  = dest_q;
  assign res_o.row_out = row_q;

`ifndef ASSERT_OFF
  a_base_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q < AngW'(DegFull))
    else $error("base angle out of range");

  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_d_q |-> ang_d_q < AngW'(DegFull))
    else $error("angle remainder out of range");

  a_frame_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !req_i.command |=> !valid_a_q)
    else $error("frame advance entered the line pipeline");
`endif

endmodule
